>>> rtl/core/pt2d_pkg.sv
// ----------------------------------------------------------------------------
// pt2d_pkg: shared types and constants of the 2D point transform
// Field widths, mode and register codes, the quarter-wave sine table and
// the payload structures that pass between the pipeline sections.
// ----------------------------------------------------------------------------
package pt2d_pkg;

	// Fixed field widths.
	localparam int PT_W       = 11;  // world coordinate in
	localparam int CTR_W      = 10;  // screen centre
	localparam int OFS_W      = 11;  // translation
	localparam int FACT_W     = 16;  // scale or shear factor
	localparam int ANG_W      = 9;   // angle in degrees
	localparam int TRIG_W     = 16;  // signed Q1.14 sine or cosine
	localparam int TRIG_FRAC  = 14;
	localparam int TIDX_W     = 7;   // index into the quarter-wave table
	localparam int TENT_W     = 15;  // unsigned table entry
	localparam int PROD_W     = PT_W + FACT_W;  // 27
	localparam int SUM_W      = PROD_W + 1;     // 28
	localparam int WORLD_W    = SUM_W + 1;      // 29
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int ANG_FULL    = 360;
	localparam int ANG_QUARTER = 90;

	typedef enum logic [2:0] {
		MODE_TRANSLATE = 3'd0,
		MODE_SCALE     = 3'd1,
		MODE_ROTATE    = 3'd2,
		MODE_SHEAR_X   = 3'd3,
		MODE_SHEAR_Y   = 3'd4,
		MODE_REFL_X    = 3'd5,
		MODE_REFL_Y    = 3'd6,
		MODE_REFL_O    = 3'd7
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE     = 3'd0,
		CFG_CENTER_X = 3'd1,
		CFG_CENTER_Y = 3'd2,
		CFG_OFFSET_X = 3'd3,
		CFG_OFFSET_Y = 3'd4,
		CFG_FACTOR_X = 3'd5,
		CFG_FACTOR_Y = 3'd6,
		CFG_ANGLE    = 3'd7
	} cfg_idx_t;

	// Register reset values.
	localparam logic [CTR_W-1:0] CENTER_X_RST = 10'd319;
	localparam logic [CTR_W-1:0] CENTER_Y_RST = 10'd239;
	localparam logic signed [FACT_W-1:0] FACTOR_RST = 16'sd256;

	typedef struct packed {
		mode_t                     mode;
		logic [CTR_W-1:0]          center_x;
		logic [CTR_W-1:0]          center_y;
		logic signed [OFS_W-1:0]   offset_x;
		logic signed [OFS_W-1:0]   offset_y;
		logic signed [FACT_W-1:0]  factor_x;
		logic signed [FACT_W-1:0]  factor_y;
		logic [ANG_W-1:0]          angle;
	} cfg_t;

	// Multiplier operands: m0 = a0*b0, m1 = a1*b1, m2 = a2*b2, m3 = a3*b3.
	typedef struct packed {
		mode_t                     mode;
		logic signed [PT_W-1:0]    px;
		logic signed [PT_W-1:0]    py;
		logic signed [PT_W-1:0]    a0;
		logic signed [PT_W-1:0]    a1;
		logic signed [PT_W-1:0]    a2;
		logic signed [PT_W-1:0]    a3;
		logic signed [TRIG_W-1:0]  b0;
		logic signed [TRIG_W-1:0]  b1;
		logic signed [TRIG_W-1:0]  b2;
		logic signed [TRIG_W-1:0]  b3;
	} op_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [PT_W-1:0]    px;
		logic signed [PT_W-1:0]    py;
		logic signed [PROD_W-1:0]  m0;
		logic signed [PROD_W-1:0]  m1;
		logic signed [PROD_W-1:0]  m2;
		logic signed [PROD_W-1:0]  m3;
	} prod_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [PT_W-1:0]    px;
		logic signed [PT_W-1:0]    py;
		logic signed [SUM_W-1:0]   sx;
		logic signed [SUM_W-1:0]   sy;
	} sum_t;

	typedef struct packed {
		logic signed [WORLD_W-1:0] wx;
		logic signed [WORLD_W-1:0] wy;
	} world_t;

	// Quarter-wave sine, Q1.14, index in whole degrees 0..90.
	localparam logic [TENT_W-1:0] SIN_Q14 [91] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
		15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

endpackage

>>> rtl/core/pt2d_point_if.sv
// ----------------------------------------------------------------------------
// pt2d_point_if: world point channel
// Valid/ready channel carrying one world point per word.
// ----------------------------------------------------------------------------
interface pt2d_point_if import pt2d_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [PT_W-1:0] point_x;
	logic signed [PT_W-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

>>> rtl/core/pt2d_screen_if.sv
// ----------------------------------------------------------------------------
// pt2d_screen_if: screen position channel
// Valid/ready channel carrying one saturated screen position per word.
// ----------------------------------------------------------------------------
interface pt2d_screen_if #(
	parameter int COORD_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] screen_x;
	logic signed [COORD_WIDTH-1:0] screen_y;
	logic                          clipped;

	modport source (output valid, output screen_x, output screen_y, output clipped,
		input ready);
	modport sink   (input valid, input screen_x, input screen_y, input clipped,
		output ready);
endinterface

>>> rtl/core/pt2d_cfg.sv
// ----------------------------------------------------------------------------
// pt2d_cfg: configuration register file
// Eight write-only registers; each write keeps only the register's width.
// ----------------------------------------------------------------------------
module pt2d_cfg import pt2d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_TRANSLATE;
			cfg_q.center_x <= CENTER_X_RST;
			cfg_q.center_y <= CENTER_Y_RST;
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
			cfg_q.factor_x <= FACTOR_RST;
			cfg_q.factor_y <= FACTOR_RST;
			cfg_q.angle    <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:     cfg_q.mode     <= mode_t'(cfg_data[2:0]);
				CFG_CENTER_X: cfg_q.center_x <= cfg_data[CTR_W-1:0];
				CFG_CENTER_Y: cfg_q.center_y <= cfg_data[CTR_W-1:0];
				CFG_OFFSET_X: cfg_q.offset_x <= $signed(cfg_data[OFS_W-1:0]);
				CFG_OFFSET_Y: cfg_q.offset_y <= $signed(cfg_data[OFS_W-1:0]);
				CFG_FACTOR_X: cfg_q.factor_x <= $signed(cfg_data[FACT_W-1:0]);
				CFG_FACTOR_Y: cfg_q.factor_y <= $signed(cfg_data[FACT_W-1:0]);
				CFG_ANGLE:    cfg_q.angle    <= cfg_data[ANG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/pt2d_front.sv
// ----------------------------------------------------------------------------
// pt2d_front: input capture, angle reduction and operand selection
// Stage 1 captures the point and splits the angle into quadrant and
// remainder; stage 2 reads the sine table and picks the multiplier operands.
// ----------------------------------------------------------------------------
module pt2d_front import pt2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	pt2d_point_if.sink   point,
	output logic         op_valid,
	input  logic         op_ready,
	output op_t          op
);

	logic                   v_s1;
	logic signed [PT_W-1:0] px_s1;
	logic signed [PT_W-1:0] py_s1;
	mode_t                  mode_s1;
	logic [1:0]             quad_s1;
	logic [TIDX_W-1:0]      rem_s1;
	logic                   v_s2;
	op_t                    op_s2;

	logic ready_s1;
	logic ready_s2;

	logic [ANG_W-1:0]  ang_red;
	logic [1:0]        quad_nx;
	logic [TIDX_W-1:0] rem_nx;

	logic signed [TRIG_W-1:0] t_dir;
	logic signed [TRIG_W-1:0] t_cmp;
	logic signed [TRIG_W-1:0] sin_v;
	logic signed [TRIG_W-1:0] cos_v;
	op_t                      op_nx;

	assign ready_s2    = !v_s2 || op_ready;
	assign ready_s1    = !v_s1 || ready_s2;
	assign point.ready = ready_s1;

	// Angle to quadrant and remainder in whole degrees.
	always_comb begin
		ang_red = (cfg.angle >= ANG_W'(ANG_FULL)) ? cfg.angle - ANG_W'(ANG_FULL) : cfg.angle;
		if (ang_red >= ANG_W'(3 * ANG_QUARTER)) begin
			quad_nx = 2'd3;
			rem_nx  = TIDX_W'(ang_red - ANG_W'(3 * ANG_QUARTER));
		end else if (ang_red >= ANG_W'(2 * ANG_QUARTER)) begin
			quad_nx = 2'd2;
			rem_nx  = TIDX_W'(ang_red - ANG_W'(2 * ANG_QUARTER));
		end else if (ang_red >= ANG_W'(ANG_QUARTER)) begin
			quad_nx = 2'd1;
			rem_nx  = TIDX_W'(ang_red - ANG_W'(ANG_QUARTER));
		end else begin
			quad_nx = 2'd0;
			rem_nx  = TIDX_W'(ang_red);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && point.valid) begin
			px_s1   <= point.point_x;
			py_s1   <= point.point_y;
			mode_s1 <= cfg.mode;
			quad_s1 <= quad_nx;
			rem_s1  <= rem_nx;
		end
	end

	// Table lookup and operand selection.
	always_comb begin
		t_dir = $signed({1'b0, SIN_Q14[rem_s1]});
		t_cmp = $signed({1'b0, SIN_Q14[TIDX_W'(ANG_QUARTER) - rem_s1]});
		case (quad_s1)
			2'd0: begin
				sin_v = t_dir;
				cos_v = t_cmp;
			end
			2'd1: begin
				sin_v = t_cmp;
				cos_v = -t_dir;
			end
			2'd2: begin
				sin_v = -t_dir;
				cos_v = -t_cmp;
			end
			default: begin
				sin_v = -t_cmp;
				cos_v = t_dir;
			end
		endcase

		op_nx      = '0;
		op_nx.mode = mode_s1;
		op_nx.px   = px_s1;
		op_nx.py   = py_s1;
		case (mode_s1)
			MODE_SCALE: begin
				op_nx.a0 = px_s1;
				op_nx.b0 = cfg.factor_x;
				op_nx.a2 = py_s1;
				op_nx.b2 = cfg.factor_y;
			end
			MODE_ROTATE: begin
				op_nx.a0 = px_s1;
				op_nx.b0 = cos_v;
				op_nx.a1 = py_s1;
				op_nx.b1 = sin_v;
				op_nx.a2 = px_s1;
				op_nx.b2 = sin_v;
				op_nx.a3 = py_s1;
				op_nx.b3 = cos_v;
			end
			MODE_SHEAR_X: begin
				op_nx.a0 = py_s1;
				op_nx.b0 = cfg.factor_x;
			end
			MODE_SHEAR_Y: begin
				op_nx.a2 = px_s1;
				op_nx.b2 = cfg.factor_y;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			op_s2 <= op_nx;
		end
	end

	assign op_valid = v_s2;
	assign op       = op_s2;

endmodule

>>> rtl/core/pt2d_arith.sv
// ----------------------------------------------------------------------------
// pt2d_arith: products, sums and world coordinates
// Stage 3 forms four products, stage 4 the two sums, stage 5 truncates
// toward zero and applies the mode to give the world coordinates.
// ----------------------------------------------------------------------------
module pt2d_arith import pt2d_pkg::*; #(
	parameter int FACTOR_FRAC_BITS = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   op_valid,
	output logic   op_ready,
	input  op_t    op,
	output logic   world_valid,
	input  logic   world_ready,
	output world_t world
);

	localparam logic signed [SUM_W:0] BIAS_F = (SUM_W+1)'((1 << FACTOR_FRAC_BITS) - 1);
	localparam logic signed [SUM_W:0] BIAS_T = (SUM_W+1)'((1 << TRIG_FRAC) - 1);
	localparam logic signed [SUM_W:0] ZERO_B = '0;

	logic   v_s3;
	logic   v_s4;
	logic   v_s5;
	prod_t  prod_s3;
	sum_t   sum_s4;
	world_t world_s5;
	logic   ready_s3;
	logic   ready_s4;
	logic   ready_s5;

	logic signed [SUM_W:0]   sx_e;
	logic signed [SUM_W:0]   sy_e;
	logic signed [SUM_W:0]   bx_f;
	logic signed [SUM_W:0]   by_f;
	logic signed [SUM_W:0]   bx_t;
	logic signed [SUM_W:0]   by_t;
	logic signed [WORLD_W-1:0] qx;
	logic signed [WORLD_W-1:0] qy;
	logic signed [WORLD_W-1:0] px_w;
	logic signed [WORLD_W-1:0] py_w;
	world_t                  world_nx;

	assign ready_s5 = !v_s5 || world_ready;
	assign ready_s4 = !v_s4 || ready_s5;
	assign ready_s3 = !v_s3 || ready_s4;
	assign op_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= op_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
			if (ready_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Stage 3: the four products, each operand sign-extended to the full
	// product width first.
	always_ff @(posedge clk) begin
		if (ready_s3 && op_valid) begin
			prod_s3.mode <= op.mode;
			prod_s3.px   <= op.px;
			prod_s3.py   <= op.py;
			prod_s3.m0   <= PROD_W'(op.a0) * PROD_W'(op.b0);
			prod_s3.m1   <= PROD_W'(op.a1) * PROD_W'(op.b1);
			prod_s3.m2   <= PROD_W'(op.a2) * PROD_W'(op.b2);
			prod_s3.m3   <= PROD_W'(op.a3) * PROD_W'(op.b3);
		end
	end

	// Stage 4: m1 and m3 are zero outside rotation.
	always_ff @(posedge clk) begin
		if (ready_s4 && v_s3) begin
			sum_s4.mode <= prod_s3.mode;
			sum_s4.px   <= prod_s3.px;
			sum_s4.py   <= prod_s3.py;
			sum_s4.sx   <= SUM_W'(prod_s3.m0) - SUM_W'(prod_s3.m1);
			sum_s4.sy   <= SUM_W'(prod_s3.m2) + SUM_W'(prod_s3.m3);
		end
	end

	// Stage 5: a negative sum is biased before the arithmetic shift so that
	// the quotient is truncated toward zero.
	always_comb begin
		sx_e = (SUM_W+1)'(sum_s4.sx);
		sy_e = (SUM_W+1)'(sum_s4.sy);
		bx_f = sx_e + (sum_s4.sx[SUM_W-1] ? BIAS_F : ZERO_B);
		by_f = sy_e + (sum_s4.sy[SUM_W-1] ? BIAS_F : ZERO_B);
		bx_t = sx_e + (sum_s4.sx[SUM_W-1] ? BIAS_T : ZERO_B);
		by_t = sy_e + (sum_s4.sy[SUM_W-1] ? BIAS_T : ZERO_B);
		if (sum_s4.mode == MODE_ROTATE) begin
			qx = WORLD_W'(bx_t >>> TRIG_FRAC);
			qy = WORLD_W'(by_t >>> TRIG_FRAC);
		end else begin
			qx = WORLD_W'(bx_f >>> FACTOR_FRAC_BITS);
			qy = WORLD_W'(by_f >>> FACTOR_FRAC_BITS);
		end
		px_w = WORLD_W'(sum_s4.px);
		py_w = WORLD_W'(sum_s4.py);

		case (sum_s4.mode)
			MODE_TRANSLATE: begin
				world_nx.wx = px_w + WORLD_W'(cfg.offset_x);
				world_nx.wy = py_w + WORLD_W'(cfg.offset_y);
			end
			MODE_SCALE, MODE_ROTATE: begin
				world_nx.wx = qx;
				world_nx.wy = qy;
			end
			MODE_SHEAR_X: begin
				world_nx.wx = px_w + qx;
				world_nx.wy = py_w;
			end
			MODE_SHEAR_Y: begin
				world_nx.wx = px_w;
				world_nx.wy = py_w + qy;
			end
			MODE_REFL_X: begin
				world_nx.wx = px_w;
				world_nx.wy = -py_w;
			end
			MODE_REFL_Y: begin
				world_nx.wx = -px_w;
				world_nx.wy = py_w;
			end
			default: begin
				world_nx.wx = -px_w;
				world_nx.wy = -py_w;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && v_s4) begin
			world_s5 <= world_nx;
		end
	end

	assign world_valid = v_s5;
	assign world       = world_s5;

endmodule

>>> rtl/core/pt2d_out.sv
// ----------------------------------------------------------------------------
// pt2d_out: screen mapping, saturation and output register
// Adds the screen centre, flips y, clamps both coordinates and holds the
// result word until the receiver takes it.
// ----------------------------------------------------------------------------
module pt2d_out import pt2d_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          world_valid,
	output logic          world_ready,
	input  world_t        world,
	pt2d_screen_if.source screen
);

	localparam int RES_W = (COORD_WIDTH > WORLD_W) ? COORD_WIDTH + 1 : WORLD_W + 2;
	localparam logic signed [RES_W-1:0] SAT_HI = (RES_W)'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - (RES_W)'(1);

	logic                          v_s6;
	logic signed [COORD_WIDTH-1:0] sx_s6;
	logic signed [COORD_WIDTH-1:0] sy_s6;
	logic                          clip_s6;
	logic                          ready_s6;

	logic signed [RES_W-1:0] cx_r;
	logic signed [RES_W-1:0] cy_r;
	logic signed [RES_W-1:0] rx;
	logic signed [RES_W-1:0] ry;
	logic signed [RES_W-1:0] rx_sat;
	logic signed [RES_W-1:0] ry_sat;
	logic                    clip_nx;

	assign ready_s6    = !v_s6 || screen.ready;
	assign world_ready = ready_s6;

	always_comb begin
		cx_r    = $signed({{(RES_W-CTR_W){1'b0}}, cfg.center_x});
		cy_r    = $signed({{(RES_W-CTR_W){1'b0}}, cfg.center_y});
		rx      = cx_r + RES_W'(world.wx);
		ry      = cy_r - RES_W'(world.wy);
		clip_nx = 1'b0;
		rx_sat  = rx;
		ry_sat  = ry;
		if (rx > SAT_HI) begin
			rx_sat  = SAT_HI;
			clip_nx = 1'b1;
		end else if (rx < SAT_LO) begin
			rx_sat  = SAT_LO;
			clip_nx = 1'b1;
		end
		if (ry > SAT_HI) begin
			ry_sat  = SAT_HI;
			clip_nx = 1'b1;
		end else if (ry < SAT_LO) begin
			ry_sat  = SAT_LO;
			clip_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (ready_s6) begin
			v_s6 <= world_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s6 && world_valid) begin
			sx_s6   <= rx_sat[COORD_WIDTH-1:0];
			sy_s6   <= ry_sat[COORD_WIDTH-1:0];
			clip_s6 <= clip_nx;
		end
	end

	assign screen.valid    = v_s6;
	assign screen.screen_x = sx_s6;
	assign screen.screen_y = sy_s6;
	assign screen.clipped  = clip_s6;

endmodule

>>> rtl/core/point_transform_2d.sv
// ----------------------------------------------------------------------------
// point_transform_2d: 2D affine transform of world points to screen space
// Translates, scales, rotates, shears or reflects each world point, then
// places it about the configured screen centre with screen y pointing down.
// ----------------------------------------------------------------------------
// Usage.
// Points arrive as words on the point channel and leave as screen words on
// the screen channel, both valid/ready. A word moves on a rising clock edge
// at which valid and ready are both high. Exactly one screen word leaves for
// every point word taken, in the same order.
// The pipeline has six register stages, s1 to s6; the screen word is valid once
// its point has passed through all of them, and can then be taken.
// In steady state, while the screen channel does not stall, one word per cycle
// is taken and delivered, since each stage hands its word on in each cycle.
// Each stage holds its word while the one after it is full and stalled, so a
// stall at the screen channel fills the pipeline from the back and only then
// lowers ready on the point channel; no word is lost or repeated.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data while the pipeline is empty; writes at other times are not
// guarded. Reset clears all valid bits and loads the register reset values
// (translate mode, centre 319/239, unity factors, zero angle).
// ----------------------------------------------------------------------------
module point_transform_2d import pt2d_pkg::*; #(
	parameter int COORD_WIDTH      = 16,
	parameter int FACTOR_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pt2d_point_if.sink            point,
	pt2d_screen_if.source         screen,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg;
	logic   op_valid;
	logic   op_ready;
	op_t    op;
	logic   world_valid;
	logic   world_ready;
	world_t world;

	// Registers; user keeps values constant while words are in flight, unchecked.
	pt2d_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stages one and two: capture, angle reduction, sine table, operands.
	pt2d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.point    (point),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	// Stages three to five: products, sums and world coordinates.
	pt2d_arith #(
		.FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
	) u_arith (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.op_valid    (op_valid),
		.op_ready    (op_ready),
		.op          (op),
		.world_valid (world_valid),
		.world_ready (world_ready),
		.world       (world)
	);

	// Stage six: screen centre, saturation and the output register.
	pt2d_out #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.world_valid (world_valid),
		.world_ready (world_ready),
		.world       (world),
		.screen      (screen)
	);

endmodule
